// ----- rtl/mbq_pkg.sv -----
`timescale 1ns / 1ps

package mbq_pkg;

	localparam int NUM_CHANNELS = 8;
	localparam int CH_ADDR_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int FRAC_BITS    = 14;

	localparam int SAMPLE_W  = 16;
	localparam int CHAN_W    = 3;
	localparam int COEF_W    = 24;
	localparam int WET_W     = 15;
	localparam int OHIST_W   = 32;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_COEFS = 5;

	localparam int HIST_W = 2 * SAMPLE_W + 2 * OHIST_W;
	localparam int PROD_W = COEF_W + OHIST_W;
	localparam int ACC_W  = PROD_W + 3;
	localparam int DIFF_W = OHIST_W + 1;
	localparam int MIX_W  = DIFF_W + WET_W + 1;
	localparam int RES_W  = MIX_W - FRAC_BITS + 1;

	localparam int SAMPLE_MAX = 2 ** (SAMPLE_W - 1) - 1;
	localparam int SAMPLE_MIN = -(2 ** (SAMPLE_W - 1));

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FF0,
		REG_FF1,
		REG_FF2,
		REG_FB1,
		REG_FB2,
		REG_WET
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_UPD,
		ST_MIX
	} state_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] x1;
		logic [SAMPLE_W-1:0] x2;
		logic [OHIST_W-1:0]  y1;
		logic [OHIST_W-1:0]  y2;
	} hist_t;

endpackage

// ----- rtl/mbq_ram.sv -----
`timescale 1ns / 1ps

module mbq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/multichannel_biquad_q14_wet_mix.sv -----
`timescale 1ns / 1ps

// Eight-channel direct-form-I biquad with Q14 coefficients and a Q14 wet/dry mix, saturated
// to 16 bits. Each channel's history sits in one synchronous RAM, read at the edge that takes
// a word and written back once the filter output is known; reset marks every channel empty,
// so its history reads as zero until first used. In ST_MAC the one shared 24x32 multiplier
// forms the five filter taps (the RAM read lands with acceptance); ST_UPD registers the mix
// product and writes the history back; ST_MIX forms the mix sum and saturation and loads
// the result once the output register is free. One word is in work at a time; a finished
// result waits in the output register while the next word is taken. A channel number beyond
// the channel count goes straight to ST_MIX and passes the sample through untouched.
// Coefficients are to be written only while the block is idle; the block does not enforce it.

module multichannel_biquad_q14_wet_mix (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [mbq_pkg::SAMPLE_W-1:0]        s_tdata,   // sample_in
	input  logic [mbq_pkg::CHAN_W-1:0]          s_tuser,   // chan_sel
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [mbq_pkg::SAMPLE_W-1:0]        m_tdata,   // sample_out
	input  logic                                cfg_we,
	input  logic [mbq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mbq_pkg::CFG_W-1:0]           cfg_data
);

	mbq_pkg::state_t state_q, state_d;

	logic [mbq_pkg::COEF_W-1:0]    coef_q [mbq_pkg::NUM_COEFS];
	logic [mbq_pkg::WET_W-1:0]     wet_q;
	logic [mbq_pkg::NUM_CHANNELS-1:0] vld_q;

	logic [mbq_pkg::SAMPLE_W-1:0]  x_q;
	logic [mbq_pkg::CH_ADDR_W-1:0] ch_q;
	logic                          byp_q;
	logic                          rd_vld_q;

	mbq_pkg::reg_idx_t             term_q;
	mbq_pkg::reg_idx_t             prod_term_q;
	logic                          prod_vld_q;
	logic signed [mbq_pkg::PROD_W-1:0] prod_q;
	logic signed [mbq_pkg::ACC_W-1:0]  acc_q;
	logic signed [mbq_pkg::MIX_W-1:0]  mprod_q;

	logic                          m_tvalid_q;
	logic [mbq_pkg::SAMPLE_W-1:0]  m_tdata_q;

	logic                          s_acc;
	logic                          out_free;
	logic                          in_byp;
	logic [mbq_pkg::CH_ADDR_W-1:0] in_addr;

	logic                          ram_re;
	logic                          ram_we;
	logic                          load_out;
	logic [mbq_pkg::HIST_W-1:0]    ram_rdata;
	mbq_pkg::hist_t                hist;
	mbq_pkg::hist_t                hist_new;

	logic signed [mbq_pkg::OHIST_W-1:0] mul_b;
	logic signed [mbq_pkg::PROD_W-1:0]  mul_p;
	logic                               mul_en;
	logic                               last_term;
	logic [mbq_pkg::OHIST_W-1:0]        y;
	logic signed [mbq_pkg::DIFF_W-1:0]  diff;
	logic signed [mbq_pkg::WET_W:0]     wet_s;
	logic signed [mbq_pkg::RES_W-1:0]   mix_sh;
	logic signed [mbq_pkg::RES_W-1:0]   mix_r;
	logic [mbq_pkg::SAMPLE_W-1:0]       sat;

	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign in_byp   = int'(s_tuser) >= mbq_pkg::NUM_CHANNELS;
	assign in_addr  = mbq_pkg::CH_ADDR_W'(s_tuser);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	mbq_ram #(
		.WIDTH(mbq_pkg::HIST_W),
		.DEPTH(mbq_pkg::NUM_CHANNELS)
	) u_hist_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ch_q),
		.wdata(hist_new),
		.re   (ram_re),
		.raddr(in_addr),
		.rdata(ram_rdata)
	);

	// empty channel reads as zero history
	assign hist = rd_vld_q ? mbq_pkg::hist_t'(ram_rdata) : '0;

	always_comb begin
		state_d = state_q;
		case (state_q)
			mbq_pkg::ST_IDLE: begin
				if (s_acc) begin
					state_d = in_byp ? mbq_pkg::ST_MIX : mbq_pkg::ST_MAC;
				end
			end
			mbq_pkg::ST_MAC: begin
				if (last_term) begin
					state_d = mbq_pkg::ST_UPD;
				end
			end
			mbq_pkg::ST_UPD: begin
				state_d = mbq_pkg::ST_MIX;
			end
			mbq_pkg::ST_MIX: begin
				if (out_free) begin
					state_d = mbq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mbq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		ram_re   = 1'b0;
		ram_we   = 1'b0;
		load_out = 1'b0;
		mul_en   = 1'b0;
		case (state_q)
			mbq_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				ram_re   = s_tvalid && !in_byp;
			end
			mbq_pkg::ST_MAC: begin
				mul_en = term_q inside {[mbq_pkg::REG_FF0 : mbq_pkg::REG_FB2]};
			end
			mbq_pkg::ST_UPD: begin
				ram_we = 1'b1;
			end
			mbq_pkg::ST_MIX: begin
				load_out = out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign last_term = prod_vld_q && (prod_term_q == mbq_pkg::REG_FB2);

	always_comb begin
		case (term_q)
			mbq_pkg::REG_FF0: mul_b = mbq_pkg::OHIST_W'($signed(x_q));
			mbq_pkg::REG_FF1: mul_b = mbq_pkg::OHIST_W'($signed(hist.x1));
			mbq_pkg::REG_FF2: mul_b = mbq_pkg::OHIST_W'($signed(hist.x2));
			mbq_pkg::REG_FB1: mul_b = $signed(hist.y1);
			mbq_pkg::REG_FB2: mul_b = $signed(hist.y2);
			default:          mul_b = '0;
		endcase
	end

	assign mul_p = $signed(coef_q[term_q]) * mul_b;

	assign y        = acc_q[mbq_pkg::FRAC_BITS +: mbq_pkg::OHIST_W];
	assign diff     = mbq_pkg::DIFF_W'($signed(y)) - mbq_pkg::DIFF_W'($signed(x_q));
	assign wet_s    = $signed({1'b0, wet_q});

	assign hist_new.x1 = x_q;
	assign hist_new.x2 = hist.x1;
	assign hist_new.y1 = y;
	assign hist_new.y2 = hist.y1;

	assign mix_sh = byp_q ? '0 : mbq_pkg::RES_W'($signed(mprod_q[mbq_pkg::MIX_W-1:mbq_pkg::FRAC_BITS]));
	assign mix_r  = mix_sh + mbq_pkg::RES_W'($signed(x_q));

	always_comb begin
		if (mix_r > mbq_pkg::RES_W'(mbq_pkg::SAMPLE_MAX)) begin
			sat = {1'b0, {(mbq_pkg::SAMPLE_W-1){1'b1}}};
		end else if (mix_r < mbq_pkg::RES_W'(mbq_pkg::SAMPLE_MIN)) begin
			sat = {1'b1, {(mbq_pkg::SAMPLE_W-1){1'b0}}};
		end else begin
			sat = mix_r[mbq_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mbq_pkg::ST_IDLE;
			m_tvalid_q <= 1'b0;
			vld_q      <= '0;
			wet_q      <= mbq_pkg::WET_W'(16384);
			for (int i = 0; i < mbq_pkg::NUM_COEFS; i++) begin
				coef_q[i] <= (i == int'(mbq_pkg::REG_FF0)) ? mbq_pkg::COEF_W'(16384) : '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					mbq_pkg::REG_FF0, mbq_pkg::REG_FF1, mbq_pkg::REG_FF2,
					mbq_pkg::REG_FB1, mbq_pkg::REG_FB2: begin
						coef_q[cfg_index] <= cfg_data;
					end
					mbq_pkg::REG_WET: begin
						wet_q <= cfg_data[mbq_pkg::WET_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (ram_we) begin
				vld_q[ch_q] <= 1'b1;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			x_q         <= s_tdata;
			ch_q        <= in_addr;
			byp_q       <= in_byp;
			rd_vld_q    <= in_byp ? 1'b0 : vld_q[in_addr];
			term_q      <= mbq_pkg::REG_FF0;
			prod_vld_q  <= 1'b0;
			acc_q       <= '0;
		end else if (state_q == mbq_pkg::ST_MAC) begin
			prod_vld_q <= mul_en;
			if (mul_en) begin
				prod_q      <= mul_p;
				prod_term_q <= term_q;
				term_q      <= mbq_pkg::reg_idx_t'(term_q + 1'b1);
			end
			if (prod_vld_q) begin
				if (prod_term_q inside {mbq_pkg::REG_FB1, mbq_pkg::REG_FB2}) begin
					acc_q <= acc_q - mbq_pkg::ACC_W'(prod_q);
				end else begin
					acc_q <= acc_q + mbq_pkg::ACC_W'(prod_q);
				end
			end
		end
		if (state_q == mbq_pkg::ST_UPD) begin
			mprod_q <= diff * wet_s;
		end
		if (load_out) begin
			m_tdata_q <= sat;
		end
	end

endmodule

// ----- rtl/mbq_chk.sv -----
`timescale 1ns / 1ps

module mbq_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [mbq_pkg::SAMPLE_W-1:0] m_tdata
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a word is in work");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without a word in work");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

bind multichannel_biquad_q14_wet_mix mbq_chk u_mbq_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
